/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* hw/rtl/llwd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llwd_pkg
// shared types and field widths for the least loaded worker dispatcher
// ----------------------------------------------------------------------------
package llwd_pkg;

  localparam int OPCODE_W = 2;
  localparam int WORKER_W = 4;
  localparam int WEIGHT_W = 8;
  localparam int TOTAL_W  = 20;
  localparam int ACTIVE_W = 5;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_QUERY = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

endpackage

/* hw/rtl/llwd_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llwd_req_if
// event channel: opcode, worker, weight and excluded worker
// ----------------------------------------------------------------------------
interface llwd_req_if import llwd_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [WORKER_W-1:0] worker;
  logic [WEIGHT_W-1:0] weight;
  logic [WORKER_W-1:0] exclude_worker;

  modport src (output valid, output opcode, output worker, output weight,
               output exclude_worker, input ready);
  modport snk (input valid, input opcode, input worker, input weight,
               input exclude_worker, output ready);

endinterface

/* hw/rtl/llwd_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llwd_res_if
// result channel: selections, total load and underflow flag
// ----------------------------------------------------------------------------
interface llwd_res_if import llwd_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [WORKER_W-1:0] least_worker;
  logic [WORKER_W-1:0] excluding_worker;
  logic                excluding_valid;
  logic [TOTAL_W-1:0]  total_load;
  logic                underflow;

  modport src (output valid, output least_worker, output excluding_worker,
               output excluding_valid, output total_load, output underflow,
               input ready);
  modport snk (input valid, input least_worker, input excluding_worker,
               input excluding_valid, input total_load, input underflow,
               output ready);

endinterface

/* hw/rtl/llwd_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llwd_cell
// one worker: load counter with saturating update, plus one step of the
// running min / excluding min / total sweep handed on to the next cell
// ----------------------------------------------------------------------------
module llwd_cell import llwd_pkg::*; #(
  parameter int IDX        = 0,
  parameter int LOAD_WIDTH = 16,
  parameter int IDX_W      = 4,
  parameter int NUM_W      = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // counter update
  input  logic                  upd_i,
  input  op_e                   opcode_i,
  input  logic [WORKER_W-1:0]   worker_i,
  input  logic [WEIGHT_W-1:0]   weight_i,
  output logic                  uf_o,
  // sweep settings
  input  logic [WORKER_W-1:0]   excl_i,
  input  logic [NUM_W-1:0]      n_eff_i,
  // sweep from previous cell
  input  logic                  tok_i,
  input  logic                  have_best_i,
  input  logic [IDX_W-1:0]      best_idx_i,
  input  logic [LOAD_WIDTH-1:0] best_val_i,
  input  logic                  have_x_i,
  input  logic [IDX_W-1:0]      x_idx_i,
  input  logic [LOAD_WIDTH-1:0] x_val_i,
  input  logic [TOTAL_W-1:0]    total_i,
  // sweep to next cell
  output logic                  tok_o,
  output logic                  have_best_o,
  output logic [IDX_W-1:0]      best_idx_o,
  output logic [LOAD_WIDTH-1:0] best_val_o,
  output logic                  have_x_o,
  output logic [IDX_W-1:0]      x_idx_o,
  output logic [LOAD_WIDTH-1:0] x_val_o,
  output logic [TOTAL_W-1:0]    total_o
);

  localparam int CW = (IDX_W > WORKER_W) ? IDX_W : WORKER_W;
  localparam int SW = ((LOAD_WIDTH > TOTAL_W) ? LOAD_WIDTH : TOTAL_W) + 1;
  localparam logic [CW-1:0]    MY_IDX = CW'(IDX);
  localparam logic [IDX_W-1:0] MY_IDX_N = IDX_W'(IDX);

  logic [LOAD_WIDTH-1:0] cnt_q, cnt_d;
  logic [LOAD_WIDTH:0]   add_sum;
  logic [LOAD_WIDTH-1:0] weight_ext;
  logic                  hit, under;
  logic                  active, is_excl, take_best, take_x;
  logic [SW-1:0]         tsum;
  logic [TOTAL_W-1:0]    total_sat;

  logic                  tok_q;
  logic                  have_best_q, have_x_q;
  logic [IDX_W-1:0]      best_idx_q, x_idx_q;
  logic [LOAD_WIDTH-1:0] best_val_q, x_val_q;
  logic [TOTAL_W-1:0]    total_q;

  assign hit        = (CW'(worker_i) == MY_IDX);
  assign weight_ext = LOAD_WIDTH'(weight_i);
  assign add_sum    = {1'b0, cnt_q} + (LOAD_WIDTH + 1)'(weight_i);
  assign under      = (weight_ext > cnt_q);

  always_comb begin
    cnt_d = cnt_q;
    case (opcode_i)
      OP_ADD: begin
        cnt_d = add_sum[LOAD_WIDTH] ? '1 : add_sum[LOAD_WIDTH-1:0];
      end
      OP_SUB: begin
        cnt_d = under ? '0 : (cnt_q - weight_ext);
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  assign uf_o = upd_i && hit && (opcode_i == OP_SUB) && under;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (upd_i && hit) begin
      cnt_q <= cnt_d;
    end
  end

  // sweep step
  assign active    = (NUM_W'(IDX) < n_eff_i);
  assign is_excl   = (CW'(excl_i) == MY_IDX);
  assign take_best = !have_best_i || (cnt_q < best_val_i);
  assign take_x    = !is_excl && (!have_x_i || (cnt_q < x_val_i));
  assign tsum      = SW'(total_i) + SW'(cnt_q);
  assign total_sat = (tsum > SW'(TOTAL_MAX)) ? TOTAL_MAX : tsum[TOTAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      have_best_q <= have_best_i;
      best_idx_q  <= best_idx_i;
      best_val_q  <= best_val_i;
      have_x_q    <= have_x_i;
      x_idx_q     <= x_idx_i;
      x_val_q     <= x_val_i;
      total_q     <= total_i;
      if (active) begin
        total_q <= total_sat;
        if (take_best) begin
          have_best_q <= 1'b1;
          best_idx_q  <= MY_IDX_N;
          best_val_q  <= cnt_q;
        end
        if (take_x) begin
          have_x_q <= 1'b1;
          x_idx_q  <= MY_IDX_N;
          x_val_q  <= cnt_q;
        end
      end
    end
  end

  assign tok_o       = tok_q;
  assign have_best_o = have_best_q;
  assign best_idx_o  = best_idx_q;
  assign best_val_o  = best_val_q;
  assign have_x_o    = have_x_q;
  assign x_idx_o     = x_idx_q;
  assign x_val_o     = x_val_q;
  assign total_o     = total_q;

endmodule

/* hw/rtl/least_loaded_worker_dispatch.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// least_loaded_worker_dispatch
// weighted load counter per worker; after each event reports the least
// loaded active worker, the least loaded one bar an excluded worker, and
// the total load of the active workers
// item path: start register, each worker cell's sweep register, done flag,
//   output register; no new item is taken until the sweep, walking one cell
//   per cycle down the row of worker cells, has moved its result to the
//   output register; a new item is taken while that result waits there
// reset: all counters cleared, active_workers = 16, both channels empty
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module least_loaded_worker_dispatch import llwd_pkg::*; #(
  parameter int MAX_WORKERS = 16,
  parameter int LOAD_WIDTH  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [ACTIVE_W-1:0] cfg_wdata_i,
  llwd_req_if.snk             req_i,
  llwd_res_if.src             res_o
);

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int NUM_W = $clog2(MAX_WORKERS + 1);
  localparam int AW    = (NUM_W > ACTIVE_W) ? NUM_W : ACTIVE_W;

  logic [ACTIVE_W-1:0] active_q;
  logic [AW-1:0]       act_ext;
  logic [NUM_W-1:0]    n_eff;

  logic                accept, load;
  logic                busy_q, done_q, start_q, uf_q;
  logic [WORKER_W-1:0] excl_q;
  logic [MAX_WORKERS-1:0] uf;

  logic [MAX_WORKERS:0]                 tok;
  logic [MAX_WORKERS:0]                 have_best, have_x;
  logic [MAX_WORKERS:0][IDX_W-1:0]      best_idx, x_idx;
  logic [MAX_WORKERS:0][LOAD_WIDTH-1:0] best_val, x_val;
  logic [MAX_WORKERS:0][TOTAL_W-1:0]    total;

  logic                out_valid_q;
  logic [WORKER_W-1:0] least_q, excl_res_q;
  logic                excl_valid_q;
  logic [TOTAL_W-1:0]  total_q;
  logic                out_uf_q;
  logic                multi;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RST;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // zero acts as one, anything above the row length as the row length
  assign act_ext = AW'(active_q);
  always_comb begin
    if (act_ext == '0) begin
      n_eff = NUM_W'(1);
    end else if (act_ext > AW'(MAX_WORKERS)) begin
      n_eff = NUM_W'(MAX_WORKERS);
    end else begin
      n_eff = NUM_W'(act_ext);
    end
  end
  assign multi = (n_eff >= NUM_W'(2));

  assign req_i.ready = !busy_q;
  assign accept      = req_i.valid && !busy_q;
  assign load        = done_q && (!out_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      start_q <= 1'b0;
    end else begin
      start_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (tok[MAX_WORKERS]) begin
        done_q <= 1'b1;
      end else if (load) begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      excl_q <= req_i.exclude_worker;
      uf_q   <= |uf;
    end
  end

  // sweep seed
  assign tok[0]       = start_q;
  assign have_best[0] = 1'b0;
  assign best_idx[0]  = '0;
  assign best_val[0]  = '0;
  assign have_x[0]    = 1'b0;
  assign x_idx[0]     = '0;
  assign x_val[0]     = '0;
  assign total[0]     = '0;

  for (genvar k = 0; k < MAX_WORKERS; k++) begin : g_cell
    llwd_cell #(
      .IDX        (k),
      .LOAD_WIDTH (LOAD_WIDTH),
      .IDX_W      (IDX_W),
      .NUM_W      (NUM_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .upd_i       (accept),
      .opcode_i    (op_e'(req_i.opcode)),
      .worker_i    (req_i.worker),
      .weight_i    (req_i.weight),
      .uf_o        (uf[k]),
      .excl_i      (excl_q),
      .n_eff_i     (n_eff),
      .tok_i       (tok[k]),
      .have_best_i (have_best[k]),
      .best_idx_i  (best_idx[k]),
      .best_val_i  (best_val[k]),
      .have_x_i    (have_x[k]),
      .x_idx_i     (x_idx[k]),
      .x_val_i     (x_val[k]),
      .total_i     (total[k]),
      .tok_o       (tok[k+1]),
      .have_best_o (have_best[k+1]),
      .best_idx_o  (best_idx[k+1]),
      .best_val_o  (best_val[k+1]),
      .have_x_o    (have_x[k+1]),
      .x_idx_o     (x_idx[k+1]),
      .x_val_o     (x_val[k+1]),
      .total_o     (total[k+1])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      least_q      <= WORKER_W'(best_idx[MAX_WORKERS]);
      excl_valid_q <= multi && have_x[MAX_WORKERS];
      excl_res_q   <= (multi && have_x[MAX_WORKERS]) ?
                      WORKER_W'(x_idx[MAX_WORKERS]) : '0;
      total_q      <= total[MAX_WORKERS];
      out_uf_q     <= uf_q;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.least_worker     = least_q;
  assign res_o.excluding_worker = excl_res_q;
  assign res_o.excluding_valid  = excl_valid_q;
  assign res_o.total_load       = total_q;
  assign res_o.underflow        = out_uf_q;

  `ASSERT_AT(a_one_sweep, $onehot0(tok), "more than one sweep in flight")
  `ASSERT_NEVER(a_done_idle, done_q && !busy_q, "sweep finished with no item in flight")
  `ASSERT_AT(a_tok_busy, (|tok) |-> (busy_q && !done_q), "sweep running outside an item")
  `ASSERT_AT(a_acc_start, accept |=> tok[0], "accepted item did not start a sweep")

endmodule
